### src/rss_pkg.sv
// ----------------------------------------------------------------------------
// rss_pkg
// Shared types for the record selection sort: the stored record and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rss_pkg;

   localparam int KEY_W = 16;
   localparam int ABS_W = 10;
   localparam int TAG_W = 8;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [ABS_W-1:0] absences;
      logic [TAG_W-1:0] tag;
   } rec_type;

   // controller to datapath
   typedef struct packed {
      logic load_en;    // store the incoming request at the write address
      logic rd_en;      // read the store at the read address
      logic rd_head;    // that read starts a pass: it seeds the running record
      logic emit;       // move the running record to the output register
      logic emit_last;  // the emitted record closes the sorted run
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic slot_free;  // output register can take a record this cycle
   } status_type;

endpackage

`default_nettype wire

### src/rss_dpath.sv
// ----------------------------------------------------------------------------
// rss_dpath
// Record store, running record of the current pass with its compare and
// exchange, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rss_dpath #(
   parameter int MAX_RECORDS = 32,
   parameter int AW          = $clog2(MAX_RECORDS)
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire rss_pkg::cmd_type        cmd,
   input  wire [AW-1:0]                 wr_addr,
   input  wire [AW-1:0]                 rd_addr,
   output rss_pkg::status_type          status,
   input  wire [rss_pkg::KEY_W-1:0]     req_sort_key,
   input  wire [rss_pkg::ABS_W-1:0]     req_absences,
   input  wire [rss_pkg::TAG_W-1:0]     req_record_tag,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic [rss_pkg::KEY_W-1:0]    rsp_out_key,
   output logic [rss_pkg::ABS_W-1:0]    rsp_out_absences,
   output logic [rss_pkg::TAG_W-1:0]    rsp_out_tag,
   output logic                         rsp_out_last
);
   import rss_pkg::*;

   rec_type         store_ff [MAX_RECORDS];
   rec_type         rdata_ff;
   logic            rd_valid_ff;
   logic            rd_head_ff;
   logic [AW-1:0]   rd_addr_ff;
   rec_type         cur_ff;
   rec_type         cur_in;
   logic            swap;
   logic            mem_we;
   logic [AW-1:0]   mem_waddr;
   rec_type         mem_wdata;
   logic            out_valid_ff;
   logic            out_valid_in;
   rec_type         out_rec_ff;
   logic            out_last_ff;
   logic            slot_free;

   // exchange rule: later record wins when running key <= its key
   assign swap = rd_valid_ff && !rd_head_ff && (cur_ff.key <= rdata_ff.key);

   always_comb begin
      cur_in = cur_ff;
      if (rd_valid_ff && (rd_head_ff || swap)) begin
         cur_in = rdata_ff;
      end
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = wr_addr;
      mem_wdata = '{key: req_sort_key, absences: req_absences, tag: req_record_tag};
      if (cmd.load_en) begin
         mem_we = 1'b1;
      end else if (swap) begin
         // the displaced running record takes the slot just read
         mem_we    = 1'b1;
         mem_waddr = rd_addr_ff;
         mem_wdata = cur_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_ff[mem_waddr] <= mem_wdata;
      end
      if (cmd.rd_en) begin
         rdata_ff   <= store_ff[rd_addr];
         rd_addr_ff <= rd_addr;
      end
   end

   assign slot_free        = !out_valid_ff || !rsp_stall;
   assign status.slot_free = slot_free;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.emit) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff  <= 1'b0;
         rd_head_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff  <= cmd.rd_en;
         rd_head_ff   <= cmd.rd_head;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (cmd.emit) begin
         out_rec_ff  <= cur_in;
         out_last_ff <= cmd.emit_last;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_out_key      = out_rec_ff.key;
   assign rsp_out_absences = out_rec_ff.absences;
   assign rsp_out_tag      = out_rec_ff.tag;
   assign rsp_out_last     = out_last_ff;

endmodule

`default_nettype wire

### src/rss_ctrl.sv
// ----------------------------------------------------------------------------
// rss_ctrl
// Sequencer: counts stored records, then walks the sort passes and issues
// store reads and output moves to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module rss_ctrl #(
   parameter int MAX_RECORDS = 32,
   parameter int AW          = $clog2(MAX_RECORDS)
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   input  wire                     req_final_item,
   output logic                    req_stall,
   output rss_pkg::cmd_type        cmd,
   output logic [AW-1:0]           wr_addr,
   output logic [AW-1:0]           rd_addr,
   input  wire rss_pkg::status_type status
);
   import rss_pkg::*;

   localparam int CW = $clog2(MAX_RECORDS + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SCAN,
      ST_EMIT
   } state_type;

   state_type       state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [CW-1:0]   i_ff, i_in;
   logic [CW-1:0]   j_ff, j_in;
   logic            last_pass;

   assign last_pass = (i_ff + CW'(1)) == count_ff;

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      cmd       = '0;
      wr_addr   = count_ff[AW-1:0];
      rd_addr   = i_ff[AW-1:0];
      req_stall = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               // records past capacity are dropped
               if (count_ff < CW'(MAX_RECORDS)) begin
                  cmd.load_en = 1'b1;
                  count_in    = count_ff + CW'(1);
               end
               if (req_final_item) begin
                  i_in     = '0;
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_head = 1'b1;
            j_in        = i_ff + CW'(1);
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            if (j_ff < count_ff) begin
               cmd.rd_en = 1'b1;
               rd_addr   = j_ff[AW-1:0];
               j_in      = j_ff + CW'(1);
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.slot_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_last = last_pass;
               if (last_pass) begin
                  count_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  i_in     = i_ff + CW'(1);
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         i_ff     <= '0;
         j_ff     <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
      end
   end

endmodule

`default_nettype wire

### src/record_selection_sort_desc.sv
// ----------------------------------------------------------------------------
// record_selection_sort_desc
// Collects records and returns them sorted by descending key.
// ----------------------------------------------------------------------------
// Each request carries one record; up to MAX_RECORDS are kept and later
// ones are dropped. A request with req_final_item set closes the set: the
// block then stalls requests and sorts with a selection pass per output
// position, one compare of a running record against one store entry per
// cycle, limited by the single read port of the record store. Pass i emits
// record i as soon as it ends and the output register can take it. Equal
// keys: a later record displaces the running one, so of equal keys the last
// in scan order comes first in each pass. rsp_out_last marks the final
// record; the store then empties and new requests are taken while that
// last result may still wait in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module record_selection_sort_desc #(
   parameter int MAX_RECORDS = 32
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire [rss_pkg::KEY_W-1:0]     req_sort_key,
   input  wire [rss_pkg::ABS_W-1:0]     req_absences,
   input  wire [rss_pkg::TAG_W-1:0]     req_record_tag,
   input  wire                          req_final_item,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic [rss_pkg::KEY_W-1:0]    rsp_out_key,
   output logic [rss_pkg::ABS_W-1:0]    rsp_out_absences,
   output logic [rss_pkg::TAG_W-1:0]    rsp_out_tag,
   output logic                         rsp_out_last
);
   import rss_pkg::*;

   localparam int AW = $clog2(MAX_RECORDS);

   cmd_type      cmd;
   status_type   status;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;

   rss_ctrl #(
      .MAX_RECORDS (MAX_RECORDS),
      .AW          (AW)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_final_item (req_final_item),
      .req_stall      (req_stall),
      .cmd            (cmd),
      .wr_addr        (wr_addr),
      .rd_addr        (rd_addr),
      .status         (status)
   );

   rss_dpath #(
      .MAX_RECORDS (MAX_RECORDS),
      .AW          (AW)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .wr_addr          (wr_addr),
      .rd_addr          (rd_addr),
      .status           (status),
      .req_sort_key     (req_sort_key),
      .req_absences     (req_absences),
      .req_record_tag   (req_record_tag),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_key      (rsp_out_key),
      .rsp_out_absences (rsp_out_absences),
      .rsp_out_tag      (rsp_out_tag),
      .rsp_out_last     (rsp_out_last)
   );

endmodule

`default_nettype wire

### src/rss_checker.sv
// ----------------------------------------------------------------------------
// rss_checker
// Port-level checks for the record sort, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rss_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          req_valid,
   input wire                          req_stall,
   input wire                          req_final_item,
   input wire                          rsp_valid,
   input wire                          rsp_stall,
   input wire [rss_pkg::KEY_W-1:0]     rsp_out_key,
   input wire [rss_pkg::ABS_W-1:0]     rsp_out_absences,
   input wire [rss_pkg::TAG_W-1:0]     rsp_out_tag,
   input wire                          rsp_out_last
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_key)
         && $stable(rsp_out_absences) && $stable(rsp_out_tag) && $stable(rsp_out_last))
      else $error("stalled result changed");

   // the final request of a set starts the sort, so requests stall next
   a_final_starts_sort: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_final_item |=> req_stall)
      else $error("no sort after final request");

   // mid-run results only appear while the block is still sorting
   a_midrun_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_last |-> req_stall)
      else $error("requests taken during a sorted run");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("reset left the block busy");

endmodule

bind record_selection_sort_desc rss_checker u_rss_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_final_item   (req_final_item),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_out_key      (rsp_out_key),
   .rsp_out_absences (rsp_out_absences),
   .rsp_out_tag      (rsp_out_tag),
   .rsp_out_last     (rsp_out_last)
);

`default_nettype wire
